// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/oal_pkg.sv
package oal_pkg;

    localparam int CAPACITY_DEF = 8;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FN_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_position;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

endpackage

// File: hdl/oal_ifs.sv
interface oal_req_if;
    import oal_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic signed [POS_W-1:0]  position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface oal_rsp_if;
    import oal_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_position;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found_position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_position, input entry_count,
                    output ready);
endinterface

// File: hdl/ordered_array_list_engine_top.sv
// A transfer whose result needs no store access goes from idle straight to the done state;
// a find reads and compares one entry at a time, a delete moves one entry at a time, and an
// insert moves one entry at a time and then writes the value. One item is handled at a time,
// set by the single store read port and the shared step and compare unit.
// Reset (synchronous, active low) empties the list and the output register; no clearing pass.
`include "assert_macros.svh"

module ordered_array_list_engine_top #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_req_if.sink   i_req,
    oal_rsp_if.source o_rsp
);
    import oal_pkg::*;

    // Index width for the store and count width that can hold the full capacity.
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [IW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    logic              w_rsp_valid;
    logic              w_rsp_ready;
    t_result           w_rsp;

    logic              r_out_valid;
    t_result           r_out;

    // The sequencer owns the list count and walks the store one entry per read, with a
    // write for each entry moved. Find scans upward from position zero and stops at the
    // first match. Insert moves entries up from the top down to the target, then writes
    // the value. Delete moves entries down from the target to the top; the freed slot
    // lies at or above the new count and is never read again, so it is left as it is.
    oal_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (w_rsp_ready),
        .o_rsp       (w_rsp),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    oal_store #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: it decouples the sequencer from the consumer, so the
    // sequencer can return to idle and accept the next transfer while a finished
    // result still waits to be taken.
    assign w_rsp_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_valid && w_rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_valid && w_rsp_ready) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.found_position = r_out.found_position;
    assign o_rsp.entry_count    = r_out.entry_count;

    `AST_NEXT(a_rsp_loaded, i_clk, i_rst_n, w_rsp_valid && w_rsp_ready, r_out_valid && (r_out == $past(w_rsp)))
    `AST_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, !w_rsp_ready)

endmodule

// File: hdl/oal_store.sv
module oal_store #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [IW-1:0]             i_wr_addr,
    input  logic [oal_pkg::DATA_W-1:0] i_wr_data,
    input  logic [IW-1:0]             i_rd_addr,
    output logic [oal_pkg::DATA_W-1:0] o_rd_data
);
    import oal_pkg::*;

    // Entries at or above the count are never read, so the array needs no clearing.
    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/oal_ctrl.sv
`include "assert_macros.svh"

module oal_ctrl #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    oal_req_if.sink                    i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output oal_pkg::t_result           o_rsp,
    output logic                       o_wr_en,
    output logic [IW-1:0]              o_wr_addr,
    output logic [oal_pkg::DATA_W-1:0] o_wr_data,
    output logic [IW-1:0]              o_rd_addr,
    input  logic [oal_pkg::DATA_W-1:0] i_rd_data
);
    import oal_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          r_state,  n_state;
    logic [FUNC_W-1:0]   r_func,   n_func;
    logic [DATA_W-1:0]   r_value,  n_value;
    logic [CW-1:0]       r_idx,    n_idx;
    logic [CW-1:0]       r_limit,  n_limit;
    logic [CW-1:0]       r_count,  n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [FOUND_W-1:0]  r_found,  n_found;

    logic [CW-1:0]       w_step;
    logic [CW-1:0]       w_pos;
    logic [POS_W-1:0]    w_pos_mag;
    logic                w_ins_ok;
    logic                w_del_ok;

    // The shared step unit: walks up for find and delete, down for insert.
    assign w_step = (r_func == FN_INSERT) ? (r_idx - CW'(1)) : (r_idx + CW'(1));

    assign w_pos_mag = {1'b0, i_req.position[POS_W-2:0]};
    assign w_pos     = CW'(i_req.position[POS_W-2:0]);
    assign w_ins_ok  = !i_req.position[POS_W-1] && (w_pos_mag <= POS_W'(r_count));
    assign w_del_ok  = !i_req.position[POS_W-1] && (w_pos_mag <  POS_W'(r_count));

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_value     = r_value;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_count     = r_count;
        n_status    = r_status;
        n_found     = r_found;
        i_req.ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx[IW-1:0];
        o_wr_data   = i_rd_data;
        o_rd_addr   = r_idx[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_value  = $unsigned(i_req.value);
                    n_status = ST_OK;
                    n_found  = '0;
                    n_state  = S_DONE;
                    unique case (i_req.func)
                        FN_FIND: begin
                            n_idx   = '0;
                            n_limit = r_count - CW'(1);
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        FN_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (!w_ins_ok) begin
                                n_status = ST_ILLEGAL;
                            end else begin
                                n_idx   = r_count;
                                n_limit = w_pos;
                                n_state = (r_count == w_pos) ? S_PUT : S_RD;
                            end
                        end
                        FN_DELETE: begin
                            if (!w_del_ok) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = w_pos;
                                n_limit = r_count - CW'(1);
                                if (w_pos == r_count - CW'(1)) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    n_state = S_RD;
                                end
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_rd_addr = (r_func == FN_FIND) ? r_idx[IW-1:0] : w_step[IW-1:0];
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (r_func == FN_FIND) begin
                    if (i_rd_data == r_value) begin
                        n_found = FOUND_W'(r_idx);
                        n_state = S_DONE;
                    end else if (r_idx == r_limit) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = w_step;
                        n_state = S_RD;
                    end
                end else begin
                    o_wr_en = 1'b1;
                    n_idx   = w_step;
                    if (w_step == r_limit) begin
                        if (r_func == FN_INSERT) begin
                            n_state = S_PUT;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_limit[IW-1:0];
                o_wr_data = r_value;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_limit  <= n_limit;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_rsp.status         = r_status;
    assign o_rsp.found_position = r_found;
    assign o_rsp.entry_count    = COUNT_W'(r_count);

    `AST_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `AST_NEXT(a_full_reject, i_clk, i_rst_n, (r_state == S_IDLE) && i_req.valid && (i_req.func == FN_INSERT) && (r_count == CW'(CAPACITY)), (r_state == S_DONE) && (r_status == ST_FULL))
    `AST_NEXT(a_count_step, i_clk, i_rst_n, r_state != S_DONE, (r_count == $past(r_count)) || (r_count == CW'($past(r_count) + CW'(1))) || (r_count == CW'($past(r_count) - CW'(1))))

endmodule

// File: dv/ordered_array_list_engine_top_tb.sv
`timescale 1ns / 100ps

module ordered_array_list_engine_top_tb;
    import oal_pkg::*;

    // The list under test keeps the package's default capacity.
    localparam int LIST_DEPTH = CAPACITY_DEF;

    // The fourth function code has no name in the package. The block must leave the
    // list alone and still return one result for it.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    // The receiver holds ready low over this hold-off while the sender keeps
    // offering, so the block backs up and has to stall its request side.
    localparam int HOLD_CYCLES  = 300;
    // The slowest operation walks all eight entries of the list. The tail after the
    // last result gives a stray extra result time to show up.
    localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 8;
    // The longest quiet stretch of a correct run is the hold-off above, plus some
    // unlucky runs of random stalls. The limit sits well above both.
    localparam int STALL_LIMIT  = 2000;

    // Where the expectation of a directed row comes from.
    localparam logic FROM_MODEL = 1'b0;
    localparam logic FROM_TABLE = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic              source;
        t_result           expected;
    } t_stim_row;

    // The directed walk. Rows whose result is obvious carry it here; the others are
    // checked against the list model. The comment on each row gives the list contents
    // after that row has been applied.
    localparam int N_DIRECTED = 25;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Empty list: a find misses, a delete hits nothing, inserts past the end or at
        // the most negative position are illegal.
        '{FN_FIND,   32'h0000_0000, 8'h00, FROM_TABLE, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{FN_DELETE, 32'h0000_0000, 8'h00, FROM_TABLE, '{ST_EMPTY,     6'd0, 7'd0}},
        '{FN_INSERT, 32'h0000_0001, 8'h01, FROM_TABLE, '{ST_ILLEGAL,   6'd0, 7'd0}},
        '{FN_INSERT, 32'h0000_0001, 8'h80, FROM_TABLE, '{ST_ILLEGAL,   6'd0, 7'd0}},
        // [MIN]
        '{FN_INSERT, 32'h8000_0000, 8'h00, FROM_TABLE, '{ST_OK,        6'd0, 7'd1}},
        // [MIN, MAX]
        '{FN_INSERT, 32'h7FFF_FFFF, 8'h01, FROM_TABLE, '{ST_OK,        6'd0, 7'd2}},
        // [0, MIN, MAX]
        '{FN_INSERT, 32'h0000_0000, 8'h00, FROM_MODEL, '0},
        '{FN_FIND,   32'h7FFF_FFFF, 8'h00, FROM_MODEL, '0},
        '{FN_FIND,   32'hFFFF_FFFF, 8'h00, FROM_MODEL, '0},
        '{FN_UNUSED, 32'hFFFF_FFFF, 8'h7F, FROM_MODEL, '0},
        // [0, MIN, MAX, 5], then [0, 5, MIN, MAX, 5]; the find must report the lower 5.
        '{FN_INSERT, 32'h0000_0005, 8'h03, FROM_MODEL, '0},
        '{FN_INSERT, 32'h0000_0005, 8'h01, FROM_MODEL, '0},
        '{FN_FIND,   32'h0000_0005, 8'h00, FROM_MODEL, '0},
        '{FN_INSERT, 32'hFFFF_FFFF, 8'h7F, FROM_TABLE, '{ST_ILLEGAL,   6'd0, 7'd5}},
        // Fill up to eight entries, the last one appended at the top.
        '{FN_INSERT, 32'h5555_5555, 8'h02, FROM_MODEL, '0},
        '{FN_INSERT, 32'hAAAA_AAAA, 8'h06, FROM_MODEL, '0},
        '{FN_INSERT, 32'h0000_0007, 8'h07, FROM_MODEL, '0},
        // A full list reports full even when the position is also illegal.
        '{FN_INSERT, 32'h0000_0009, 8'hFF, FROM_TABLE, '{ST_FULL,      6'd0, 7'd8}},
        '{FN_INSERT, 32'h0000_0009, 8'h00, FROM_TABLE, '{ST_FULL,      6'd0, 7'd8}},
        '{FN_FIND,   32'h0000_0007, 8'h00, FROM_MODEL, '0},
        // Deletes at count and at a negative position find nothing to remove.
        '{FN_DELETE, 32'h0000_0000, 8'h08, FROM_TABLE, '{ST_EMPTY,     6'd0, 7'd8}},
        '{FN_DELETE, 32'h0000_0000, 8'hFF, FROM_TABLE, '{ST_EMPTY,     6'd0, 7'd8}},
        // Remove the top entry, then the bottom one, which is the only stored zero.
        '{FN_DELETE, 32'h0000_0000, 8'h07, FROM_MODEL, '0},
        '{FN_DELETE, 32'h0000_0000, 8'h00, FROM_MODEL, '0},
        // The list holds no zero now, and the freed slots above count must not match.
        '{FN_FIND,   32'h0000_0000, 8'h00, FROM_MODEL, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    oal_req_if req_if ();
    oal_rsp_if rsp_if ();

    ordered_array_list_engine_top #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow copy of the list, advanced once per accepted request transfer.
    logic signed [DATA_W-1:0] list_entries [LIST_DEPTH];
    int                       list_count;

    // Results owed by the block, oldest first.
    t_result pending_results [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void clear_list_model();
        int idx;
        for (idx = 0; idx < LIST_DEPTH; idx++) begin
            list_entries[idx] = '0;
        end
        list_count = 0;
    endfunction

    // Applies one operation to the shadow list and returns the result the block owes
    // for it. Fullness is tested before the insert position, and a delete clears the
    // slot that falls free at the top of the list.
    function automatic t_result apply_list_op(input logic [FUNC_W-1:0] op,
                                              input logic signed [DATA_W-1:0] value,
                                              input logic signed [POS_W-1:0] position);
        t_result res;
        int      pos_i;
        int      idx;
        bit      hit;
        res   = '0;
        pos_i = int'(position);
        hit   = 1'b0;
        case (op)
            FN_FIND: begin
                res.status = ST_NOT_FOUND;
                for (idx = 0; idx < list_count && !hit; idx++) begin
                    if (list_entries[idx] == value) begin
                        hit                = 1'b1;
                        res.status         = ST_OK;
                        res.found_position = idx[FOUND_W-1:0];
                    end
                end
            end
            FN_INSERT: begin
                if (list_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (pos_i < 0 || pos_i > list_count) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    for (idx = list_count; idx > pos_i; idx--) begin
                        list_entries[idx] = list_entries[idx-1];
                    end
                    list_entries[pos_i] = value;
                    list_count++;
                end
            end
            FN_DELETE: begin
                if (pos_i < 0 || pos_i >= list_count) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (idx = pos_i; idx + 1 < list_count; idx++) begin
                        list_entries[idx] = list_entries[idx+1];
                    end
                    list_count--;
                    list_entries[list_count] = '0;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = list_count[COUNT_W-1:0];
        return res;
    endfunction

    // Offers one request and returns in the time step of the edge that accepted it.
    // Valid stays high from one request to the next unless a random gap is drawn.
    task automatic offer_request(input logic [FUNC_W-1:0] op,
                                 input logic signed [DATA_W-1:0] value,
                                 input logic signed [POS_W-1:0] position);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= op;
        req_if.value    <= value;
        req_if.position <= position;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    // Sends one request and records what it must produce. A typed expectation from the
    // directed rows takes the place of the model's, but the model still advances so
    // the later rows and the random part start from the right list.
    task automatic send_list_op(input logic [FUNC_W-1:0] op,
                                input logic signed [DATA_W-1:0] value,
                                input logic signed [POS_W-1:0] position,
                                input logic source,
                                input t_result typed_result);
        t_result modeled;
        offer_request(op, value, position);
        modeled = apply_list_op(op, value, position);
        pending_results.push_back(source == FROM_TABLE ? typed_result : modeled);
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending, actual status %0d position %0d count %0d",
                     $time, got.status, got.found_position, got.entry_count);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.found_position !== want.found_position) begin
                $display("%0t: found_position mismatch, expected %0d, actual %0d",
                         $time, want.found_position, got.found_position);
                error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                         $time, want.entry_count, got.entry_count);
                error_count++;
            end
        end
    endtask

    // Receiver. Every edge first samples a completed result transfer and then decides
    // the ready level for the next cycle, so ready gets one assignment per time step.
    initial begin
        int hold_left;
        hold_left    = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                check_result('{rsp_if.status, rsp_if.found_position, rsp_if.entry_count});
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog. It counts cycles in which neither side completes a transfer; a run
    // that goes quiet for too long has hung.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and the final verdict.
    initial begin
        int                       item;
        int                       roll;
        logic [FUNC_W-1:0]        op;
        logic signed [DATA_W-1:0] value;
        logic signed [POS_W-1:0]  position;

        error_count   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 55;
        clear_list_model();

        req_if.valid    <= 1'b0;
        req_if.func     <= FN_FIND;
        req_if.value    <= '0;
        req_if.position <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (item = 0; item < N_DIRECTED; item++) begin
            send_list_op(DIRECTED_ROWS[item].op, DIRECTED_ROWS[item].value,
                         DIRECTED_ROWS[item].position, DIRECTED_ROWS[item].source,
                         DIRECTED_ROWS[item].expected);
        end

        // Random part in three phases: a slow receiver, then a slow sender, then no
        // idling at all. The last phase opens with the long receiver hold-off.
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == PHASE_ITEMS) begin
                send_idle_pct = 55;
                recv_idle_pct = 11;
            end else if (item == 2 * PHASE_ITEMS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end

            // Inserts slightly outweigh deletes, so the list wanders over its whole
            // range from empty to full and spends time at both ends.
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = FN_UNUSED;
            end else if (roll < 38) begin
                op = FN_FIND;
            end else if (roll < 72) begin
                op = FN_INSERT;
            end else begin
                op = FN_DELETE;
            end

            // Half of the finds on a non-empty list look for a stored word. Small values make duplicates common,
            // so the lowest-match rule gets exercised.
            roll = $urandom_range(0, 99);
            if (op == FN_FIND && list_count > 0 && roll < 50) begin
                value = list_entries[$urandom_range(0, list_count - 1)];
            end else if (roll < 75) begin
                value = $urandom_range(0, 7);
            end else begin
                value = $urandom();
            end

            // Most positions are in range for an insert; the rest cover all eight bits.
            if ($urandom_range(0, 99) < 85) begin
                position = POS_W'($urandom_range(0, list_count));
            end else begin
                position = POS_W'($urandom_range(0, 255));
            end

            send_list_op(op, value, position, FROM_MODEL, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
